// ----- hw/rtl/twd_pkg.sv -----
package twd_pkg;

   localparam int POOL_SIZE   = 1024;
   localparam int BRANCHES    = 26;
   localparam int NODE_W      = $clog2(POOL_SIZE);
   localparam int FREE_W      = NODE_W + 1;
   localparam int IDX_W       = $clog2(BRANCHES);
   localparam int SLOT_DEPTH  = POOL_SIZE * BRANCHES;
   localparam int SLOT_W      = $clog2(SLOT_DEPTH);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   localparam logic [7:0] LETTER_BASE = 8'd97;

   typedef enum logic [1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_REMOVE = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_NORMAL    = 2'd0,
      ST_BAD_CHAR  = 2'd1,
      ST_POOL_FULL = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type          cmd;
      logic [IDX_W-1:0] idx;
      logic             bad_char;
      logic             last;
      logic             empty;
   } op_type;

endpackage

// ----- hw/rtl/twd_ram.sv -----
module twd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/twd_front.sv -----
module twd_front
   import twd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [1:0] in_command,
   input  logic [7:0] in_character,
   input  logic       in_last,
   input  logic       in_empty,
   output logic       op_valid,
   input  logic       op_ready,
   output op_type     op
);

   op_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;
   op_type             cls;
   logic [7:0]         offset;
   logic               push, pop;

   always_comb begin
      offset       = in_character - LETTER_BASE;
      cls.bad_char = (in_character < LETTER_BASE) || (offset >= 8'(BRANCHES));
      cls.idx      = offset[IDX_W-1:0];
      cls.last     = in_last;
      cls.empty    = in_empty;
      unique case (in_command)
         2'd1:    cls.cmd = CMD_INSERT;
         2'd2:    cls.cmd = CMD_REMOVE;
         default: cls.cmd = CMD_LOOKUP;
      endcase
   end

   assign in_ready = (cnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign op_valid = (cnt_ff != '0);
   assign op       = entry_ff[rd_ptr_ff];
   assign push     = in_valid && in_ready;
   assign pop      = op_valid && op_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// ----- hw/rtl/twd_back.sv -----
module twd_back
   import twd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       op_valid,
   output logic       op_ready,
   input  op_type     op,
   output logic       out_valid,
   input  logic       out_ready,
   output logic       out_success,
   output status_type out_status
);

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_CHK   = 4'b0100,
      S_MARK  = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [NODE_W-1:0]  node_ff, node_in;
   logic [FREE_W-1:0]  free_ff, free_in;
   logic               failed_ff, failed_in;
   status_type         pstat_ff, pstat_in;
   cmd_type            cmd_ff, cmd_in;
   logic               last_ff, last_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [SLOT_W-1:0]  clr_ff, clr_in;
   logic               out_valid_ff, out_valid_in;
   logic               out_success_ff, out_success_in;
   status_type         out_status_ff, out_status_in;

   logic               child_wr_en, child_rd_en;
   logic [SLOT_W-1:0]  child_wr_addr, child_rd_addr;
   logic [NODE_W-1:0]  child_wr_data, child_rd_data;
   logic               mark_wr_en, mark_rd_en, mark_wr_data, mark_rd_data;
   logic [NODE_W-1:0]  mark_wr_addr, mark_rd_addr;
   logic               take;

   assign op_ready = (state_ff == S_IDLE);
   assign take     = op_valid && op_ready;

   always_comb begin
      state_in       = state_ff;
      node_in        = node_ff;
      free_in        = free_ff;
      failed_in      = failed_ff;
      pstat_in       = pstat_ff;
      cmd_in         = cmd_ff;
      last_in        = last_ff;
      slot_in        = slot_ff;
      clr_in         = clr_ff;
      out_valid_in   = out_valid_ff && !out_ready;
      out_success_in = out_success_ff;
      out_status_in  = out_status_ff;
      child_wr_en    = 1'b0;
      child_wr_addr  = slot_ff;
      child_wr_data  = '0;
      child_rd_en    = 1'b0;
      child_rd_addr  = SLOT_W'(node_ff) * SLOT_W'(BRANCHES) + SLOT_W'(op.idx);
      mark_wr_en     = 1'b0;
      mark_wr_addr   = node_ff;
      mark_wr_data   = 1'b0;
      mark_rd_en     = 1'b0;
      mark_rd_addr   = node_ff;

      unique case (state_ff)
         S_CLEAR: begin
            child_wr_en   = 1'b1;
            child_wr_addr = clr_ff;
            mark_wr_en    = (clr_ff < SLOT_W'(POOL_SIZE));
            mark_wr_addr  = clr_ff[NODE_W-1:0];
            clr_in        = clr_ff + 1'b1;
            if (clr_ff == SLOT_W'(SLOT_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (take) begin
               cmd_in  = op.cmd;
               last_in = op.last || op.empty;
               if (op.empty) begin
                  node_in      = '0;
                  failed_in    = 1'b0;
                  pstat_in     = ST_NORMAL;
                  mark_rd_en   = 1'b1;
                  mark_rd_addr = '0;
                  state_in     = S_MARK;
               end else if (failed_ff || op.bad_char) begin
                  if (!failed_ff) begin
                     failed_in = 1'b1;
                     pstat_in  = ST_BAD_CHAR;
                  end
                  if (op.last) begin
                     state_in = S_MARK;
                  end
               end else begin
                  child_rd_en = 1'b1;
                  slot_in     = child_rd_addr;
                  state_in    = S_CHK;
               end
            end
         end
         S_CHK: begin
            if (child_rd_data != '0 &&
                FREE_W'(child_rd_data) < FREE_W'(POOL_SIZE)) begin
               node_in = child_rd_data;
            end else if (cmd_ff == CMD_INSERT) begin
               if (free_ff < FREE_W'(POOL_SIZE)) begin
                  child_wr_en   = 1'b1;
                  child_wr_data = free_ff[NODE_W-1:0];
                  node_in       = free_ff[NODE_W-1:0];
                  free_in       = free_ff + 1'b1;
               end else begin
                  failed_in = 1'b1;
                  pstat_in  = ST_POOL_FULL;
               end
            end else begin
               failed_in = 1'b1;
               pstat_in  = ST_NORMAL;
            end
            mark_rd_addr = node_in;
            if (last_ff) begin
               mark_rd_en = 1'b1;
               state_in   = S_MARK;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_MARK: begin
            if (!out_valid_ff || out_ready) begin
               out_valid_in = 1'b1;
               if (failed_ff) begin
                  out_success_in = 1'b0;
                  out_status_in  = pstat_ff;
               end else begin
                  out_status_in = ST_NORMAL;
                  unique case (cmd_ff)
                     CMD_INSERT: begin
                        out_success_in = !mark_rd_data;
                        mark_wr_en     = 1'b1;
                        mark_wr_data   = 1'b1;
                     end
                     CMD_REMOVE: begin
                        out_success_in = mark_rd_data;
                        mark_wr_en     = 1'b1;
                        mark_wr_data   = 1'b0;
                     end
                     default: begin
                        out_success_in = mark_rd_data;
                     end
                  endcase
               end
               node_in   = '0;
               failed_in = 1'b0;
               pstat_in  = ST_NORMAL;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         node_ff      <= '0;
         free_ff      <= FREE_W'(1);
         failed_ff    <= 1'b0;
         pstat_ff     <= ST_NORMAL;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         node_ff      <= node_in;
         free_ff      <= free_in;
         failed_ff    <= failed_in;
         pstat_ff     <= pstat_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      last_ff        <= last_in;
      slot_ff        <= slot_in;
      out_success_ff <= out_success_in;
      out_status_ff  <= out_status_in;
   end

   twd_ram #(
      .WIDTH (NODE_W),
      .DEPTH (SLOT_DEPTH)
   ) u_child_ram (
      .clock   (clock),
      .wr_en   (child_wr_en),
      .wr_addr (child_wr_addr),
      .wr_data (child_wr_data),
      .rd_en   (child_rd_en),
      .rd_addr (child_rd_addr),
      .rd_data (child_rd_data)
   );

   twd_ram #(
      .WIDTH (1),
      .DEPTH (POOL_SIZE)
   ) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_wr_en),
      .wr_addr (mark_wr_addr),
      .wr_data (mark_wr_data),
      .rd_en   (mark_rd_en),
      .rd_addr (mark_rd_addr),
      .rd_data (mark_rd_data)
   );

   assign out_valid   = out_valid_ff;
   assign out_success = out_success_ff;
   assign out_status  = out_status_ff;

endmodule

// ----- hw/rtl/trie_word_dictionary_core.sv -----
// Flow: a character that does not end a word takes the child read, then check and allocate;
//   a word-ending one adds the mark read and update; an empty word, or the end of a word that
//   has already failed, goes straight to the mark step. A new character waits until the last
//   is through, set by the dependent child table read; a failed word's characters skip it.
// Reset: synchronous; afterward a clearing pass over all 26624 child slots zeroes the child
//   table and end marks, while up to 4 items queue at the input.
module trie_word_dictionary_core
   import twd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // command[1:0], character[9:2], zero[15:10]
   input  logic        req_tlast,
   input  logic        req_tuser,  // empty_word[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata   // success[0], status[2:1], zero[7:3]
);

   logic       op_valid, op_ready;
   op_type     op;
   logic       success;
   status_type status;

   twd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_command   (req_tdata[1:0]),
      .in_character (req_tdata[9:2]),
      .in_last      (req_tlast),
      .in_empty     (req_tuser),
      .op_valid     (op_valid),
      .op_ready     (op_ready),
      .op           (op)
   );

   twd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .op_valid    (op_valid),
      .op_ready    (op_ready),
      .op          (op),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_success (success),
      .out_status  (status)
   );

   assign rsp_tdata = {5'd0, status, success};

endmodule

// ----- hw/rtl/twd_checker.sv -----
module twd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic        req_tlast,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=>
         req_tvalid && $stable({req_tdata, req_tlast, req_tuser}))
      else $error("req item dropped or changed while stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item dropped or changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:1] != 2'd3)
      else $error("undefined status code");

   a_fail_no_success: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:1] != 2'd0 |-> !rsp_tdata[0])
      else $error("success reported with error status");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:3] == 5'd0)
      else $error("rsp padding bits not zero");

endmodule

bind trie_word_dictionary_core twd_checker u_twd_checker (.*);

// ----- tb/trie_word_dictionary_core_tb.sv -----
module trie_word_dictionary_core_tb;
   import twd_pkg::*;

   localparam logic [1:0] CMD_RESERVED = 2'd3;
   localparam logic [7:0] LETTER_Z     = 8'(LETTER_BASE + BRANCHES - 1);

   typedef struct {
      logic [1:0] cmd;
      logic [7:0] ch;
      logic       last;
      logic       empty;
   } word_item;

   typedef struct {
      logic       success;
      status_type status;
   } word_outcome;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // command[1:0], character[9:2], zero[15:10]
   logic        req_tlast = 1'b0;
   logic        req_tuser = 1'b0; // empty_word[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;       // success[0], status[2:1], zero[7:3]

   trie_word_dictionary_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // trie mirror
   bit [NODE_W-1:0] trie_child [SLOT_DEPTH];
   bit              trie_mark  [POOL_SIZE];
   int              free_node = 1;
   int              cur_node = 0;
   bit              word_dead = 1'b0;
   status_type      dead_status = ST_NORMAL;

   word_item    pending_q[$];
   word_outcome outcome_q[$];
   word_item    cur_item;

   bit quiet = 1'b0;
   int gap_left = 0;
   int stall_left = 0;
   int error_count = 0;
   int item_count = 0;
   int n_results = 0;
   int n_hits = 0;
   int n_bad = 0;
   int n_full = 0;
   int n_checked = 0;

   function automatic void mark_failed(input status_type code);
      if (!word_dead) begin
         word_dead   = 1'b1;
         dead_status = code;
      end
   endfunction

   function automatic void apply_trie_char(input word_item it);
      logic [1:0]  op;
      logic [7:0]  idx;
      int          slot;
      int          kid;
      bit          done;
      word_outcome res;
      op   = (it.cmd == CMD_RESERVED) ? CMD_LOOKUP : it.cmd;
      done = 1'b0;
      if (it.empty) begin
         cur_node    = 0;
         word_dead   = 1'b0;
         dead_status = ST_NORMAL;
         done        = 1'b1;
      end else begin
         if (!word_dead) begin
            idx = it.ch - LETTER_BASE;
            if (it.ch < LETTER_BASE || idx >= BRANCHES) begin
               mark_failed(ST_BAD_CHAR);
            end else begin
               slot = cur_node * BRANCHES + int'(idx);
               kid  = trie_child[slot];
               if (kid != 0) begin
                  cur_node = kid;
               end else if (op == CMD_INSERT) begin
                  if (free_node < POOL_SIZE) begin
                     trie_child[slot] = free_node[NODE_W-1:0];
                     cur_node         = free_node;
                     free_node++;
                  end else begin
                     mark_failed(ST_POOL_FULL);
                  end
               end else begin
                  mark_failed(ST_NORMAL);
               end
            end
         end
         done = it.last;
      end
      if (done) begin
         if (word_dead) begin
            res.success = 1'b0;
            res.status  = dead_status;
            if (dead_status == ST_BAD_CHAR) n_bad++;
            if (dead_status == ST_POOL_FULL) n_full++;
         end else begin
            res.status = ST_NORMAL;
            if (op == CMD_INSERT) begin
               res.success         = !trie_mark[cur_node];
               trie_mark[cur_node] = 1'b1;
            end else if (op == CMD_REMOVE) begin
               res.success         = trie_mark[cur_node];
               trie_mark[cur_node] = 1'b0;
            end else begin
               res.success = trie_mark[cur_node];
            end
            if (res.success) n_hits++;
         end
         outcome_q.push_back(res);
         n_results++;
         cur_node    = 0;
         word_dead   = 1'b0;
         dead_status = ST_NORMAL;
      end
   endfunction

   function automatic void push_item(input logic [1:0] cmd, input logic [7:0] ch,
                                     input logic last, input logic empty);
      word_item it;
      it.cmd   = cmd;
      it.ch    = ch;
      it.last  = last;
      it.empty = empty;
      pending_q.push_back(it);
      item_count++;
   endfunction

   // span limits the letters to the first span of the alphabet
   function automatic void push_word(input logic [1:0] cmd, input int len, input int span,
                                     input bit mixed, input bit noisy);
      int         bad_pos;
      logic [1:0] c;
      logic [7:0] ch;
      bad_pos = noisy ? $urandom_range(0, len - 1) : -1;
      for (int i = 0; i < len; i++) begin
         c  = (mixed && i != len - 1) ? 2'($urandom_range(0, 3)) : cmd;
         ch = (i == bad_pos) ? 8'($urandom_range(0, 255))
                             : LETTER_BASE + 8'($urandom_range(0, span - 1));
         push_item(c, ch, i == len - 1, 1'b0);
      end
   endfunction

   function automatic logic [1:0] pick_cmd();
      return ($urandom_range(0, 9) == 0) ? CMD_RESERVED : 2'($urandom_range(0, 2));
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) apply_trie_char(cur_item);
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_q.size() != 0) begin
               cur_item = pending_q.pop_front();
               req_tdata  <= {6'd0, cur_item.ch, cur_item.cmd};
               req_tlast  <= cur_item.last;
               req_tuser  <= cur_item.empty;
               req_tvalid <= 1'b1;
               if (!quiet && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 4);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (outcome_q.size() == 0) begin
               $display("%0t: unexpected result, actual success=%0b status=%0d",
                        $time, rsp_tdata[0], rsp_tdata[2:1]);
               error_count++;
            end else begin
               word_outcome want;
               want = outcome_q.pop_front();
               n_checked++;
               if (rsp_tdata[0] !== want.success) begin
                  $display("%0t: success mismatch, expected %0b actual %0b",
                           $time, want.success, rsp_tdata[0]);
                  error_count++;
               end
               if (rsp_tdata[2:1] !== want.status) begin
                  $display("%0t: status mismatch, expected %0d actual %0d",
                           $time, want.status, rsp_tdata[2:1]);
                  error_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 4);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("trie_word_dictionary_core verification failed");
      $finish;
   end

   initial begin : stimulus
      int r;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty words on the root, every command
      push_item(CMD_LOOKUP, 8'hFF, 1'b0, 1'b1);
      push_item(CMD_INSERT, 8'h00, 1'b1, 1'b1);
      push_item(CMD_INSERT, LETTER_BASE, 1'b0, 1'b1);
      push_item(CMD_REMOVE, LETTER_Z, 1'b1, 1'b1);
      push_item(CMD_RESERVED, 8'h80, 1'b0, 1'b1);
      // insert and find the extreme letters
      push_item(CMD_INSERT, LETTER_BASE, 1'b0, 1'b0);
      push_item(CMD_INSERT, LETTER_Z, 1'b1, 1'b0);
      push_item(CMD_RESERVED, LETTER_BASE, 1'b0, 1'b0);
      push_item(CMD_RESERVED, LETTER_Z, 1'b1, 1'b0);
      push_item(CMD_LOOKUP, LETTER_BASE, 1'b1, 1'b0);
      // invalid bytes around the letter range
      push_item(CMD_INSERT, LETTER_BASE - 8'd1, 1'b0, 1'b0);
      push_item(CMD_INSERT, LETTER_BASE + 8'd1, 1'b1, 1'b0);
      push_item(CMD_INSERT, LETTER_Z + 8'd1, 1'b1, 1'b0);
      push_item(CMD_LOOKUP, 8'h00, 1'b1, 1'b0);
      push_item(CMD_REMOVE, 8'hFF, 1'b0, 1'b0);
      push_item(CMD_REMOVE, 8'h80, 1'b0, 1'b0);
      push_item(CMD_REMOVE, LETTER_BASE, 1'b1, 1'b0);
      // missing child, then a bad byte: the first status holds
      push_item(CMD_LOOKUP, LETTER_BASE + 8'd16, 1'b0, 1'b0);
      push_item(CMD_LOOKUP, LETTER_BASE - 8'd1, 1'b1, 1'b0);
      // remove twice
      push_item(CMD_REMOVE, LETTER_BASE, 1'b0, 1'b0);
      push_item(CMD_REMOVE, LETTER_Z, 1'b1, 1'b0);
      push_item(CMD_REMOVE, LETTER_BASE, 1'b0, 1'b0);
      push_item(CMD_REMOVE, LETTER_Z, 1'b1, 1'b0);
      // mixed commands within one word
      push_item(CMD_INSERT, LETTER_BASE + 8'd1, 1'b0, 1'b0);
      push_item(CMD_LOOKUP, LETTER_BASE + 8'd2, 1'b1, 1'b0);
      push_item(CMD_LOOKUP, LETTER_BASE, 1'b0, 1'b0);
      push_item(CMD_INSERT, LETTER_Z - 8'd1, 1'b1, 1'b0);
      // empty word abandons a word in progress
      push_item(CMD_INSERT, LETTER_BASE + 8'd3, 1'b0, 1'b0);
      push_item(CMD_INSERT, 8'h00, 1'b0, 1'b1);

      // hold until the block has drained
      while (pending_q.size() != 0 || req_tvalid || outcome_q.size() != 0)
         @(posedge clock);

      // dense small-alphabet traffic for frequent hits
      while (item_count < 320) begin
         r = $urandom_range(0, 99);
         if (r < 70)
            push_word(pick_cmd(), $urandom_range(1, 4), 4, 1'b0, 1'b0);
         else if (r < 80)
            push_item(pick_cmd(), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
         else if (r < 90)
            push_word(pick_cmd(), $urandom_range(1, 4), 4, 1'b0, 1'b1);
         else
            push_word(pick_cmd(), $urandom_range(2, 5), 4, 1'b1, 1'b0);
      end

      // long inserts until the node pool runs dry
      while (free_node < POOL_SIZE) begin
         push_word(CMD_INSERT, 16, BRANCHES, 1'b0, 1'b0);
         while (pending_q.size() != 0)
            @(posedge clock);
      end

      while (pending_q.size() != 0)
         @(posedge clock);
      quiet = 1'b1;

      // full pool, no idling
      repeat (60) begin
         r = $urandom_range(0, 99);
         if (r < 40)
            push_word(CMD_INSERT, $urandom_range(2, 6), BRANCHES, 1'b0, 1'b0);
         else if (r < 70)
            push_word(pick_cmd(), $urandom_range(1, 4), 4, 1'b0, 1'b0);
         else if (r < 85)
            push_item(pick_cmd(), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
         else
            push_word(pick_cmd(), $urandom_range(1, 4), 4, 1'b0, 1'b1);
      end

      while (pending_q.size() != 0 || req_tvalid || outcome_q.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);

      $display("Sent %0d characters, checked %0d words: %0d succeeded, %0d bad byte,",
               item_count, n_checked, n_hits, n_bad);
      $display("%0d pool full; %0d of %0d nodes allocated.", n_full, free_node, POOL_SIZE);
      if (error_count == 0 && outcome_q.size() == 0) begin
         $display("trie_word_dictionary_core verification clean");
      end else begin
         $display("trie_word_dictionary_core verification failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/twd_pkg.sv
hw/rtl/twd_ram.sv
hw/rtl/twd_front.sv
hw/rtl/twd_back.sv
hw/rtl/trie_word_dictionary_core.sv
hw/rtl/twd_checker.sv
tb/trie_word_dictionary_core_tb.sv
